### hdl/lfor_pkg.sv
// ----------------------------------------------------------------------------
// lfor_pkg
// Shared types and constants of the line framer: byte codes, result kinds
// and the command word that passes from the front end to the back end.
// ----------------------------------------------------------------------------
package lfor_pkg;

  localparam int LEN_W  = 6;
  localparam int BYTE_W = 8;

  localparam logic [BYTE_W-1:0] BYTE_LF = 8'd10;
  localparam logic [BYTE_W-1:0] BYTE_CR = 8'd13;

  localparam logic [1:0]       CLOSE_STREAK   = 2'd2;
  localparam logic [1:0]       STREAK_SAT     = 2'd3;
  localparam logic [LEN_W-1:0] MAX_LINE_RESET = 6'd63;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_END   = 2'd1,
    KIND_OVF   = 2'd2,
    KIND_CLOSE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    CMD_LINE,
    CMD_OVF,
    CMD_OVF_CLOSE
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t          op;
    logic [LEN_W-1:0] len;
    logic             had_cr;
    logic             bank;
  } cmd_t;

endpackage

### hdl/lfor_ram.sv
// ----------------------------------------------------------------------------
// lfor_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module lfor_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/lfor_cmd_fifo.sv
// ----------------------------------------------------------------------------
// lfor_cmd_fifo
// Two-entry command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module lfor_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  lfor_pkg::cmd_t push_cmd,
  output logic          cmd_full,
  input  logic          pop,
  output logic          cmd_valid,
  output lfor_pkg::cmd_t cmd
);
  import lfor_pkg::*;

  localparam int DEPTH = 2;
  localparam int PTR_W = 1;

  cmd_t              q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [PTR_W:0]    count;

  assign cmd_full  = (count == (PTR_W+1)'(DEPTH));
  assign cmd_valid = (count != '0);
  assign cmd       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= push_cmd;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### hdl/lfor_front.sv
// ----------------------------------------------------------------------------
// lfor_front
// Front end: accept bytes, store line bytes into the current bank, and
// classify line ends and overflows into commands for the back end.
// ----------------------------------------------------------------------------
module lfor_front #(
  parameter int MAX_LINE = 63
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  input  logic [lfor_pkg::BYTE_W-1:0]       data_byte,
  output logic                              full,
  input  logic                              cfg_wr_en,
  input  logic [lfor_pkg::LEN_W-1:0]        cfg_wr_data,
  output logic                              wr_en,
  output logic [((MAX_LINE > 1) ? $clog2(MAX_LINE) : 1):0] wr_addr,
  output logic [lfor_pkg::BYTE_W-1:0]       wr_data,
  output logic                              cmd_push,
  output lfor_pkg::cmd_t                    push_cmd,
  input  logic                              cmd_full,
  input  logic                              line_done
);
  import lfor_pkg::*;

  localparam int AW = (MAX_LINE > 1) ? $clog2(MAX_LINE) : 1;

  logic [LEN_W-1:0] len_limit;
  logic [LEN_W-1:0] fill_count;
  logic             last_cr;
  logic             bank;
  logic             resync_mode;
  logic [1:0]       ovf_run;
  logic             closed_flag;
  logic [1:0]       lines_busy;

  logic             accept;
  logic             is_lf;
  logic [LEN_W-1:0] lim;
  logic             at_limit;
  logic             line_end;
  logic             overflow;
  logic [1:0]       streak_next;
  logic             trim_cr;

  always_comb begin
    lim = len_limit;
    if (len_limit == '0 || len_limit > LEN_W'(MAX_LINE)) begin
      lim = LEN_W'(MAX_LINE);
    end
  end

  assign full        = cmd_full || (lines_busy == 2'd2);
  assign accept      = push && !full;
  assign is_lf       = (data_byte == BYTE_LF);
  assign at_limit    = (fill_count >= lim);
  assign line_end    = accept && !closed_flag && !resync_mode && is_lf;
  assign overflow    = accept && !closed_flag && !resync_mode && !is_lf && at_limit;
  assign streak_next = (ovf_run == STREAK_SAT) ? ovf_run : ovf_run + 2'd1;
  assign trim_cr     = (fill_count != '0) && last_cr;

  assign wr_en   = accept && !closed_flag && !resync_mode && !is_lf && !at_limit;
  assign wr_addr = {bank, fill_count[AW-1:0]};
  assign wr_data = data_byte;

  assign cmd_push = line_end || overflow;

  always_comb begin
    push_cmd        = '0;
    push_cmd.bank   = bank;
    if (line_end) begin
      push_cmd.op     = CMD_LINE;
      push_cmd.len    = fill_count - LEN_W'(trim_cr);
      push_cmd.had_cr = trim_cr;
    end else if (streak_next >= CLOSE_STREAK) begin
      push_cmd.op     = CMD_OVF_CLOSE;
    end else begin
      push_cmd.op     = CMD_OVF;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len_limit   <= MAX_LINE_RESET;
      fill_count  <= '0;
      last_cr     <= 1'b0;
      bank        <= 1'b0;
      resync_mode <= 1'b0;
      ovf_run     <= '0;
      closed_flag <= 1'b0;
      lines_busy  <= '0;
    end else begin
      if (cfg_wr_en) begin
        len_limit <= cfg_wr_data;
      end
      unique case ({line_end, line_done})
        2'b10:   lines_busy <= lines_busy + 2'd1;
        2'b01:   lines_busy <= lines_busy - 2'd1;
        default: lines_busy <= lines_busy;
      endcase
      if (accept && !closed_flag) begin
        if (resync_mode) begin
          fill_count <= '0;
          if (is_lf) begin
            resync_mode <= 1'b0;
          end
        end else if (is_lf) begin
          fill_count <= '0;
          ovf_run    <= '0;
          bank       <= ~bank;
        end else if (at_limit) begin
          fill_count  <= '0;
          resync_mode <= 1'b1;
          ovf_run     <= streak_next;
          if (streak_next >= CLOSE_STREAK) begin
            closed_flag <= 1'b1;
          end
        end else begin
          fill_count <= fill_count + 1'b1;
          last_cr    <= (data_byte == BYTE_CR);
        end
      end
    end
  end

  // Both banks may be held by the back end, never more.
  a_busy_bound: assert property (@(posedge clk) disable iff (rst)
    lines_busy != 2'd3)
    else $error("line bank count out of range");

  // Once closed, stay closed until reset.
  a_closed_sticky: assert property (@(posedge clk) disable iff (rst)
    closed_flag |=> closed_flag)
    else $error("closed flag dropped without reset");

  // A line never holds more bytes than the store depth.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= LEN_W'(MAX_LINE))
    else $error("fill count past the store depth");

endmodule

### hdl/lfor_back.sv
// ----------------------------------------------------------------------------
// lfor_back
// Back end: take commands, read stored line bytes and emit result beats
// through a one-entry output register.
// ----------------------------------------------------------------------------
module lfor_back #(
  parameter int MAX_LINE = 63
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cmd_valid,
  input  lfor_pkg::cmd_t                    cmd,
  output logic                              cmd_pop,
  output logic                              rd_en,
  output logic [((MAX_LINE > 1) ? $clog2(MAX_LINE) : 1):0] rd_addr,
  input  logic [lfor_pkg::BYTE_W-1:0]       rd_data,
  output logic                              line_done,
  input  logic                              pop,
  output logic                              empty,
  output lfor_pkg::kind_t                   kind,
  output logic [lfor_pkg::BYTE_W-1:0]       out_byte,
  output logic [lfor_pkg::LEN_W-1:0]        line_length,
  output logic                              had_cr,
  output logic                              last
);
  import lfor_pkg::*;

  localparam int AW = (MAX_LINE > 1) ? $clog2(MAX_LINE) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BYTES,
    S_END,
    S_OVF,
    S_CLOSE
  } state_t;

  state_t           state;
  cmd_t             cur;
  logic [LEN_W-1:0] idx;
  logic             rd_pend;
  logic             ov_valid;
  logic             slot;
  logic             pop_fire;
  logic             ov_load;

  assign empty    = !ov_valid;
  assign pop_fire = pop && ov_valid;
  assign slot     = !ov_valid || pop_fire;
  assign cmd_pop  = (state == S_IDLE) && cmd_valid;
  assign rd_en    = (state == S_BYTES) && !rd_pend && slot;
  assign rd_addr  = {cur.bank, idx[AW-1:0]};
  assign line_done = (state == S_END) && !rd_pend && slot;
  assign ov_load  = rd_pend || line_done ||
                    (((state == S_OVF) || (state == S_CLOSE)) && slot);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      rd_pend  <= 1'b0;
      ov_valid <= 1'b0;
      idx      <= '0;
    end else begin
      if (ov_load) begin
        ov_valid <= 1'b1;
      end else if (pop_fire) begin
        ov_valid <= 1'b0;
      end
      // Land a read issued last cycle; the output register is free by then.
      rd_pend <= rd_en;
      if (rd_pend) begin
        kind        <= KIND_BYTE;
        out_byte    <= rd_data;
        line_length <= '0;
        had_cr      <= 1'b0;
        last        <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            cur <= cmd;
            idx <= '0;
            if (cmd.op == CMD_LINE) begin
              state <= (cmd.len == '0) ? S_END : S_BYTES;
            end else begin
              state <= S_OVF;
            end
          end
        end
        S_BYTES: begin
          if (rd_en) begin
            idx <= idx + 1'b1;
            if (idx == cur.len - 1'b1) begin
              state <= S_END;
            end
          end
        end
        S_END: begin
          if (line_done) begin
            kind        <= KIND_END;
            out_byte    <= '0;
            line_length <= cur.len;
            had_cr      <= cur.had_cr;
            last        <= 1'b1;
            state       <= S_IDLE;
          end
        end
        S_OVF: begin
          if (slot) begin
            kind        <= KIND_OVF;
            out_byte    <= '0;
            line_length <= '0;
            had_cr      <= 1'b0;
            last        <= (cur.op != CMD_OVF_CLOSE);
            state       <= (cur.op == CMD_OVF_CLOSE) ? S_CLOSE : S_IDLE;
          end
        end
        S_CLOSE: begin
          if (slot) begin
            kind        <= KIND_CLOSE;
            out_byte    <= '0;
            line_length <= '0;
            had_cr      <= 1'b0;
            last        <= 1'b1;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A pending read always finds the output register free.
  a_read_slot: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> !ov_valid)
    else $error("read data would overwrite a waiting beat");

  // No read is left in flight when a new command is taken.
  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !rd_pend)
    else $error("read pending while idle");

  // Line byte beats never close out an input byte.
  a_byte_not_last: assert property (@(posedge clk) disable iff (rst)
    (ov_valid && kind == KIND_BYTE) |-> !last)
    else $error("last set on a line byte beat");

endmodule

### hdl/line_framer_overflow_resync_core.sv
// ----------------------------------------------------------------------------
// line_framer_overflow_resync_core
// Line framer with a maximum line length: buffers received bytes, emits
// each complete line with an end marker, reports overflows and resyncs on
// the next LF, and closes after two overflows with no good line between.
// ----------------------------------------------------------------------------
//
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------------
//  input    | push / full            | data_byte
//  result   | empty / pop            | kind, out_byte, line_length,
//           |                        | had_cr, last
//  config   | cfg_wr_en              | cfg_wr_data (line limit)
//
//  Flow: the front end takes one byte per cycle while full is low. Each
//  line byte beat goes through the registered RAM read, then the output
//  register, and no read is issued while one is pending; an end marker,
//  overflow or close beat loads that register once its command leaves the queue.
//  Stalls: full rises while the two-entry command queue is full or both
//  line banks still wait to be drained; the result side stalls only on pop.
//  Reset: synchronous; clears control state only. The line store has no
//  clearing pass, since only entries written in the current line are read.
// ----------------------------------------------------------------------------
module line_framer_overflow_resync_core #(
  parameter int MAX_LINE = 63
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  logic [lfor_pkg::BYTE_W-1:0] data_byte,
  output logic                        full,
  input  logic                        cfg_wr_en,
  input  logic [lfor_pkg::LEN_W-1:0]  cfg_wr_data,
  input  logic                        pop,
  output logic                        empty,
  output lfor_pkg::kind_t             kind,
  output logic [lfor_pkg::BYTE_W-1:0] out_byte,
  output logic [lfor_pkg::LEN_W-1:0]  line_length,
  output logic                        had_cr,
  output logic                        last
);
  import lfor_pkg::*;

  // Two banks of line storage so one line drains while the next fills.
  localparam int AW        = (MAX_LINE > 1) ? $clog2(MAX_LINE) : 1;
  localparam int RAM_DEPTH = 2 ** (AW + 1);

  logic          wr_en;
  logic [AW:0]   wr_addr;
  logic [BYTE_W-1:0] wr_data;
  logic          rd_en;
  logic [AW:0]   rd_addr;
  logic [BYTE_W-1:0] rd_data;

  logic          cmd_push;
  cmd_t          push_cmd;
  logic          cmd_full;
  logic          cmd_valid;
  cmd_t          cmd;
  logic          cmd_pop;
  logic          line_done;

  // Accept and classify bytes; write line bytes into the current bank.
  lfor_front #(
    .MAX_LINE (MAX_LINE)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .data_byte   (data_byte),
    .full        (full),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .cmd_push    (cmd_push),
    .push_cmd    (push_cmd),
    .cmd_full    (cmd_full),
    .line_done   (line_done)
  );

  lfor_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (RAM_DEPTH)
  ) u_line_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Hold line ends and overflows until the back end is free.
  lfor_cmd_fifo u_cmd_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (cmd_push),
    .push_cmd  (push_cmd),
    .cmd_full  (cmd_full),
    .pop       (cmd_pop),
    .cmd_valid (cmd_valid),
    .cmd       (cmd)
  );

  // Drain commands into result beats.
  lfor_back #(
    .MAX_LINE (MAX_LINE)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_pop     (cmd_pop),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data),
    .line_done   (line_done),
    .pop         (pop),
    .empty       (empty),
    .kind        (kind),
    .out_byte    (out_byte),
    .line_length (line_length),
    .had_cr      (had_cr),
    .last        (last)
  );

endmodule
